// File: sv/assert_macros.svh
// Assertion macros included by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/tcprst_pkg.sv
// Constants and checksum helper for the TCP reset packet builder.
package tcprst_pkg;

    localparam int unsigned PKT_WORDS = 10;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [IDX_W-1:0]     t_word_idx;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // register indexes on the configuration port
    localparam t_cfg_idx CFG_TTL    = 3'd0;
    localparam t_cfg_idx CFG_IDENT  = 3'd1;
    localparam t_cfg_idx CFG_WINDOW = 3'd2;
    localparam t_cfg_idx CFG_ACK    = 3'd3;

    localparam logic [7:0]  RST_TTL    = 8'd64;
    localparam logic [15:0] RST_IDENT  = 16'd1337;
    localparam logic [15:0] RST_WINDOW = 16'd5000;
    localparam logic [31:0] RST_ACK    = 32'd1;

    localparam logic [31:0] IP_WORD0   = 32'h4500_0028;
    localparam logic [7:0]  IP_PROTO   = 8'h06;
    localparam logic [15:0] TCP_LEN    = 16'h0014;
    localparam logic [15:0] TCP_OFFFLG = 16'h5004;

    localparam t_word_idx LAST_IDX = t_word_idx'(PKT_WORDS - 1);

    // fold carries twice, then invert
    function automatic logic [15:0] csum_fold(input logic [19:0] acc);
        logic [16:0] a1;
        logic [16:0] a2;
        a1 = {13'd0, acc[19:16]} + {1'b0, acc[15:0]};
        a2 = {1'b0, a1[15:0]} + {16'd0, a1[16]};
        return ~a2[15:0];
    endfunction

endpackage

// File: sv/tcp_rst_packet_builder_core.sv
// Top level: TCP reset packet builder, input register, packet register, word serializer.
// One connection tuple in, one 40-byte IPv4+TCP RST packet out as ten 32-bit big-endian
// beats (word_index 0..9, last_word on the tenth). A tuple is captured in an input
// register; both checksums are computed from it in one pass and loaded with the tuple
// into the packet register, which then drives one word per cycle while i_ready is high.
// A tuple passes the input register and then the packet register before its first word
// is offered; the next tuple is taken into the input register while the current packet
// is still being sent.
// Configuration writes take effect immediately and are expected only while idle.
`include "assert_macros.svh"

module tcp_rst_packet_builder_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_wr_en,
    input  tcprst_pkg::t_cfg_idx    i_cfg_index,
    input  logic [31:0]             i_cfg_data,
    // tuple in
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [31:0]             i_source_ip,
    input  logic [31:0]             i_dest_ip,
    input  logic [15:0]             i_source_port,
    input  logic [15:0]             i_dest_port,
    input  logic [31:0]             i_sequence_number,
    // packet words out
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [31:0]             o_packet_word,
    output tcprst_pkg::t_word_idx   o_word_index,
    output logic                    o_last_word
);
    import tcprst_pkg::*;

    // configuration registers
    logic [7:0]  r_ttl;
    logic [15:0] r_ident;
    logic [15:0] r_window;
    logic [31:0] r_ack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl    <= RST_TTL;
            r_ident  <= RST_IDENT;
            r_window <= RST_WINDOW;
            r_ack    <= RST_ACK;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TTL:    r_ttl    <= i_cfg_data[7:0];
                CFG_IDENT:  r_ident  <= i_cfg_data[15:0];
                CFG_WINDOW: r_window <= i_cfg_data[15:0];
                CFG_ACK:    r_ack    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    logic        r_in_valid;
    logic [31:0] r_in_src;
    logic [31:0] r_in_dst;
    logic [15:0] r_in_sport;
    logic [15:0] r_in_dport;
    logic [31:0] r_in_seq;

    // packet register
    logic        r_pkt_valid;
    t_word_idx   r_idx;
    logic [31:0] r_src;
    logic [31:0] r_dst;
    logic [15:0] r_sport;
    logic [15:0] r_dport;
    logic [31:0] r_seq;
    logic [15:0] r_ip_csum;
    logic [15:0] r_tcp_csum;

    logic      pkt_done;
    logic      load;
    logic      out_beat;
    t_word_idx n_idx;

    assign out_beat = r_pkt_valid && i_ready;
    assign pkt_done = out_beat && (r_idx == LAST_IDX);
    assign load     = r_in_valid && (!r_pkt_valid || pkt_done);
    assign o_ready  = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_src   <= i_source_ip;
            r_in_dst   <= i_dest_ip;
            r_in_sport <= i_source_port;
            r_in_dport <= i_dest_port;
            r_in_seq   <= i_sequence_number;
        end
    end

    // checksums over the input register
    logic [19:0] ip_acc;
    logic [19:0] tcp_acc;

    always_comb begin
        ip_acc = {4'd0, IP_WORD0[31:16]} + {4'd0, IP_WORD0[15:0]}
               + {4'd0, r_ident} + {4'd0, r_ttl, IP_PROTO}
               + {4'd0, r_in_src[31:16]} + {4'd0, r_in_src[15:0]}
               + {4'd0, r_in_dst[31:16]} + {4'd0, r_in_dst[15:0]};
        // pseudo-header, then the TCP header with a zero checksum
        tcp_acc = {4'd0, r_in_src[31:16]} + {4'd0, r_in_src[15:0]}
                + {4'd0, r_in_dst[31:16]} + {4'd0, r_in_dst[15:0]}
                + {12'd0, IP_PROTO} + {4'd0, TCP_LEN}
                + {4'd0, r_in_sport} + {4'd0, r_in_dport}
                + {4'd0, r_in_seq[31:16]} + {4'd0, r_in_seq[15:0]}
                + {4'd0, r_ack[31:16]} + {4'd0, r_ack[15:0]}
                + {4'd0, TCP_OFFFLG} + {4'd0, r_window};
    end

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = '0;
        end else if (out_beat) begin
            n_idx = r_idx + t_word_idx'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_pkt_valid <= 1'b1;
            end else if (pkt_done) begin
                r_pkt_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_src      <= r_in_src;
            r_dst      <= r_in_dst;
            r_sport    <= r_in_sport;
            r_dport    <= r_in_dport;
            r_seq      <= r_in_seq;
            r_ip_csum  <= csum_fold(ip_acc);
            r_tcp_csum <= csum_fold(tcp_acc);
        end
    end

    // word serializer
    always_comb begin
        case (r_idx)
            4'd0:    o_packet_word = IP_WORD0;
            4'd1:    o_packet_word = {r_ident, 16'h0000};
            4'd2:    o_packet_word = {r_ttl, IP_PROTO, r_ip_csum};
            4'd3:    o_packet_word = r_src;
            4'd4:    o_packet_word = r_dst;
            4'd5:    o_packet_word = {r_sport, r_dport};
            4'd6:    o_packet_word = r_seq;
            4'd7:    o_packet_word = r_ack;
            4'd8:    o_packet_word = {TCP_OFFFLG, r_window};
            4'd9:    o_packet_word = {r_tcp_csum, 16'h0000};
            default: o_packet_word = '0;
        endcase
    end

    assign o_valid      = r_pkt_valid;
    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == LAST_IDX);

    `ASSERT_CLK(a_idx_range, !r_pkt_valid || (r_idx <= LAST_IDX), "word index out of range")
    `ASSERT_NEXT(a_idx_step, out_beat && !pkt_done && !load,
        r_pkt_valid && (r_idx == $past(r_idx) + t_word_idx'(1)), "word index did not advance")
    `ASSERT_NEXT(a_load_start, load, r_pkt_valid && (r_idx == '0),
        "packet did not start at word zero")
    `ASSERT_CLK(a_no_overwrite, !(r_in_valid && r_pkt_valid && !pkt_done && load),
        "packet register overwritten mid-packet")

endmodule

// File: tb/rst_packet_checker.sv
// Checker for the TCP reset packet builder: predicts each packet from the tuple and compares.
module rst_packet_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  tcprst_pkg::t_cfg_idx  i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_tuple_valid,
    input  logic                  i_tuple_ready,
    input  logic [31:0]           i_source_ip,
    input  logic [31:0]           i_dest_ip,
    input  logic [15:0]           i_source_port,
    input  logic [15:0]           i_dest_port,
    input  logic [31:0]           i_sequence_number,
    input  logic                  i_word_valid,
    input  logic                  i_word_ready,
    input  logic [31:0]           i_packet_word,
    input  tcprst_pkg::t_word_idx i_word_index,
    input  logic                  i_last_word,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcprst_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        t_word_idx   index;
        logic        last;
    } t_rst_beat;

    t_rst_beat expected_beats[$];

    // shadow copy of the header registers
    logic [7:0]  ttl_q;
    logic [15:0] ident_q;
    logic [15:0] window_q;
    logic [31:0] ack_q;

    function automatic logic [31:0] add_halves(input logic [31:0] acc, input logic [31:0] w);
        return acc + {16'd0, w[31:16]} + {16'd0, w[15:0]};
    endfunction

    function automatic logic [15:0] inet_checksum(input logic [31:0] acc);
        logic [31:0] folded;
        folded = {16'd0, acc[31:16]} + {16'd0, acc[15:0]};
        folded = folded + {16'd0, folded[31:16]};
        return ~folded[15:0];
    endfunction

    task automatic push_rst_packet(input logic [31:0] src, input logic [31:0] dst,
                                   input logic [15:0] sport, input logic [15:0] dport,
                                   input logic [31:0] seq);
        logic [31:0] pkt [PKT_WORDS];
        logic [31:0] acc;
        t_rst_beat   beat;
        pkt[0] = IP_WORD0;
        pkt[1] = {ident_q, 16'h0000};
        pkt[2] = {ttl_q, IP_PROTO, 16'h0000};
        pkt[3] = src;
        pkt[4] = dst;
        pkt[5] = {sport, dport};
        pkt[6] = seq;
        pkt[7] = ack_q;
        pkt[8] = {TCP_OFFFLG, window_q};
        pkt[9] = '0;

        acc = '0;
        for (int k = 0; k < 5; k++) acc = add_halves(acc, pkt[k]);
        pkt[2][15:0] = inet_checksum(acc);

        // pseudo-header first, then the TCP header with its checksum still zero
        acc = add_halves(32'd0, src);
        acc = add_halves(acc, dst);
        acc = add_halves(acc, {8'h00, IP_PROTO, TCP_LEN});
        for (int k = 5; k < PKT_WORDS; k++) acc = add_halves(acc, pkt[k]);
        pkt[9] = {inet_checksum(acc), 16'h0000};

        for (int k = 0; k < PKT_WORDS; k++) begin
            beat.word  = pkt[k];
            beat.index = t_word_idx'(k);
            beat.last  = (k == PKT_WORDS - 1);
            expected_beats.push_back(beat);
        end
    endtask

    always @(posedge i_clk) begin
        t_rst_beat exp_beat;
        if (!i_rst_n) begin
            ttl_q    = RST_TTL;
            ident_q  = RST_IDENT;
            window_q = RST_WINDOW;
            ack_q    = RST_ACK;
            expected_beats.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_TTL:    ttl_q    = i_cfg_data[7:0];
                    CFG_IDENT:  ident_q  = i_cfg_data[15:0];
                    CFG_WINDOW: window_q = i_cfg_data[15:0];
                    CFG_ACK:    ack_q    = i_cfg_data;
                    default:    ;
                endcase
            end

            // compare before predicting so a beat can never match its own tuple's packet early
            if (i_word_valid && i_word_ready) begin
                if (expected_beats.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected beat: expected none, actual word %h index %0d last %b",
                             $time, i_packet_word, i_word_index, i_last_word);
                end else begin
                    exp_beat = expected_beats.pop_front();
                    if (i_packet_word !== exp_beat.word) begin
                        o_fail_count++;
                        $display("%0t: packet_word (index %0d): expected %h actual %h",
                                 $time, exp_beat.index, exp_beat.word, i_packet_word);
                    end
                    if (i_word_index !== exp_beat.index) begin
                        o_fail_count++;
                        $display("%0t: word_index: expected %0d actual %0d",
                                 $time, exp_beat.index, i_word_index);
                    end
                    if (i_last_word !== exp_beat.last) begin
                        o_fail_count++;
                        $display("%0t: last_word (index %0d): expected %b actual %b",
                                 $time, exp_beat.index, exp_beat.last, i_last_word);
                    end
                end
            end

            if (i_tuple_valid && i_tuple_ready)
                push_rst_packet(i_source_ip, i_dest_ip, i_source_port, i_dest_port,
                                i_sequence_number);
        end
        o_pending = expected_beats.size();
    end

endmodule

// File: tb/tb_tcp_rst_packet_builder_core.sv
// Testbench top for the TCP reset packet builder: clock, reset, stimulus and verdict.
module tb_tcp_rst_packet_builder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tcprst_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int IDLE_PCT     = 31;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 50;
    localparam int CALM_PHASE   = 3;
    localparam int HOLD_AT      = 110;
    localparam int HOLD_LEN     = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int STALL_LIMIT  = 2000;
    localparam int NUM_REGS     = 4;

    // with a zero tuple and zero TTL/ack these make both checksums come out as zero
    localparam logic [31:0] ZERO_CSUM_IDENT  = 32'h0000_BAD1;
    localparam logic [31:0] ZERO_CSUM_WINDOW = 32'h0000_AFE1;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    t_cfg_idx    cfg_index;
    logic [31:0] cfg_data;
    logic        tuple_valid;
    logic        tuple_ready;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] sequence_number;
    logic        word_valid;
    logic        word_ready;
    logic [31:0] packet_word;
    t_word_idx   word_index;
    logic        last_word;

    int fail_count;
    int pending;
    int tuples_sent;
    bit calm;
    int stall_cycles;

    always #(CLK_PERIOD / 2) clk = ~clk;

    tcp_rst_packet_builder_core u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_valid           (tuple_valid),
        .o_ready           (tuple_ready),
        .i_source_ip       (source_ip),
        .i_dest_ip         (dest_ip),
        .i_source_port     (source_port),
        .i_dest_port       (dest_port),
        .i_sequence_number (sequence_number),
        .o_valid           (word_valid),
        .i_ready           (word_ready),
        .o_packet_word     (packet_word),
        .o_word_index      (word_index),
        .o_last_word       (last_word)
    );

    rst_packet_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_tuple_valid     (tuple_valid),
        .i_tuple_ready     (tuple_ready),
        .i_source_ip       (source_ip),
        .i_dest_ip         (dest_ip),
        .i_source_port     (source_port),
        .i_dest_port       (dest_port),
        .i_sequence_number (sequence_number),
        .i_word_valid      (word_valid),
        .i_word_ready      (word_ready),
        .i_packet_word     (packet_word),
        .i_word_index      (word_index),
        .i_last_word       (last_word),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // mostly random values, with the extremes showing up often
    function automatic logic [31:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return $urandom;
    endfunction

    task automatic send_tuple(input logic [31:0] src, input logic [31:0] dst,
                              input logic [15:0] sport, input logic [15:0] dport,
                              input logic [31:0] seq);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            tuple_valid <= 1'b0;
            @(negedge clk);
        end
        tuple_valid     <= 1'b1;
        source_ip       <= src;
        dest_ip         <= dst;
        source_port     <= sport;
        dest_port       <= dport;
        sequence_number <= seq;
        @(posedge clk);
        while (!tuple_ready) @(posedge clk);
        tuples_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_tuple();
        send_tuple(pick_value(), pick_value(), 16'(pick_value()), 16'(pick_value()),
                   pick_value());
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        tuple_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    // receiver: random back-pressure (none in the calm phase), one long hold-off once HOLD_AT tuples are sent
    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left  = 0;
        hold_done  = 1'b0;
        word_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                word_ready <= 1'b0;
                hold_left--;
            end else if (!hold_done && tuples_sent >= HOLD_AT) begin
                hold_done  = 1'b1;
                hold_left  = HOLD_LEN - 1;
                word_ready <= 1'b0;
            end else begin
                word_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog: cycles in which no beat moves on either channel
    always @(posedge clk) begin
        if (!rst_n || (tuple_valid && tuple_ready) || (word_valid && word_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_tcp_rst_packet_builder_core NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = CFG_TTL;
        cfg_data        = '0;
        tuple_valid     = 1'b0;
        source_ip       = '0;
        dest_ip         = '0;
        source_port     = '0;
        dest_port       = '0;
        sequence_number = '0;
        tuples_sent     = 0;
        calm            = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values, field extremes and alternating bit patterns
        send_tuple('0, '0, '0, '0, '0);
        send_tuple('1, '1, '1, '1, '1);
        send_tuple(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA);
        send_tuple(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 32'h5555_5555);
        send_tuple(32'h0A00_0001, 32'hC0A8_01FE, 16'd80, 16'd54321, 32'h8000_0000);
        send_tuple('1, '0, '0, '1, 32'h0000_FFFF);
        send_tuple('0, '1, '1, '0, 32'hFFFF_0000);
        wait_drained();

        // low extremes; zero tuple yields zero IP and TCP checksums
        write_reg(CFG_TTL, '0);
        write_reg(CFG_IDENT, ZERO_CSUM_IDENT);
        write_reg(CFG_WINDOW, ZERO_CSUM_WINDOW);
        write_reg(CFG_ACK, '0);
        send_tuple('0, '0, '0, '0, '0);
        send_tuple('1, '1, '1, '1, '1);
        send_tuple(32'h0000_0001, '0, '0, '0, '0);
        wait_drained();

        // high extremes, data wider than the register, index past the register list
        write_reg(CFG_TTL, '1);
        write_reg(CFG_IDENT, '1);
        write_reg(CFG_WINDOW, '1);
        write_reg(CFG_ACK, '1);
        write_reg(t_cfg_idx'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)), $urandom);
        send_tuple('1, '1, '1, '1, '1);
        send_tuple('0, '0, '0, '0, '0);
        send_tuple(32'hFFFF_FFFE, 32'h0001_0001, 16'hFFFE, 16'h0001, 32'h0001_FFFF);
        wait_drained();

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            calm = (phase == CALM_PHASE);
            if (phase != 0) begin
                write_reg(CFG_TTL, pick_value());
                write_reg(CFG_IDENT, pick_value());
                write_reg(CFG_WINDOW, pick_value());
                write_reg(CFG_ACK, pick_value());
                if ($urandom_range(2) == 0)
                    write_reg(t_cfg_idx'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                              $urandom);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) send_random_tuple();
            wait_drained();
        end
        calm = 1'b0;

        // catch stray beats after the last packet
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_tcp_rst_packet_builder_core OK");
        end else begin
            $display("tb_tcp_rst_packet_builder_core NOT OK");
        end
        $finish;
    end

endmodule
